/* rtl/vnu_pkg.sv */
// Shared types and constants for the vector normalize unit.
`timescale 1ns / 1ps
`default_nettype none

package vnu_pkg;

    localparam int COMP_W = 16;
    localparam int OUT_W  = 16;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } t_vnu_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_x;
        logic signed [OUT_W-1:0] unit_y;
        logic signed [OUT_W-1:0] unit_z;
        logic                    was_zero;
    } t_vnu_res;

    // Control that rides along each pipeline stage
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } t_vnu_ctl;

endpackage

`default_nettype wire

/* rtl/vnu_sqrt_cell.sv */
// One digit stage of the pipelined floor square root.
`timescale 1ns / 1ps
`default_nettype none

module vnu_sqrt_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  vnu_pkg::t_vnu_ctl            i_ctl,
    input  wire [3*vnu_pkg::COMP_W-1:0]  i_mag,
    input  wire [2*vnu_pkg::COMP_W-1:0]  i_sum,
    input  wire [vnu_pkg::COMP_W+1:0]    i_rem,
    input  wire [vnu_pkg::COMP_W-1:0]    i_root,
    output vnu_pkg::t_vnu_ctl            o_ctl,
    output logic [3*vnu_pkg::COMP_W-1:0] o_mag,
    output logic [2*vnu_pkg::COMP_W-1:0] o_sum,
    output logic [vnu_pkg::COMP_W+1:0]   o_rem,
    output logic [vnu_pkg::COMP_W-1:0]   o_root
);
    import vnu_pkg::*;

    localparam int W = COMP_W;

    logic [W+3:0] rem_sh;
    logic [W+3:0] trial;
    logic [W+3:0] diff;
    logic         ge;
    logic [W+1:0] n_rem;
    logic [W-1:0] n_root;
    logic [2*W-1:0] n_sum;

    t_vnu_ctl       r_ctl;
    logic [3*W-1:0] r_mag;
    logic [2*W-1:0] r_sum;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;

    always_comb begin
        rem_sh = {i_rem, i_sum[2*W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
        n_rem  = ge ? diff[W+1:0] : rem_sh[W+1:0];
        n_root = {i_root[W-2:0], ge};
        n_sum  = {i_sum[2*W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= i_mag;
        r_sum  <= n_sum;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_mag  = r_mag;
    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* rtl/vnu_div_cell.sv */
// One quotient-bit stage of the three-lane pipelined divider.
`timescale 1ns / 1ps
`default_nettype none

module vnu_div_cell #(
    parameter int FRAC_BITS = 14,
    parameter bit FIRST     = 1'b0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  vnu_pkg::t_vnu_ctl              i_ctl,
    input  wire [vnu_pkg::COMP_W-1:0]      i_len,
    input  wire [3*(vnu_pkg::COMP_W+1)-1:0] i_rem,
    input  wire [3*(FRAC_BITS+1)-1:0]      i_quo,
    output vnu_pkg::t_vnu_ctl              o_ctl,
    output logic [vnu_pkg::COMP_W-1:0]     o_len,
    output logic [3*(vnu_pkg::COMP_W+1)-1:0] o_rem,
    output logic [3*(FRAC_BITS+1)-1:0]     o_quo
);
    import vnu_pkg::*;

    localparam int W  = COMP_W;
    localparam int RW = COMP_W + 1;
    localparam int QW = FRAC_BITS + 1;

    logic [RW-1:0] rem_in [3];
    logic [QW-1:0] quo_in [3];
    logic [RW:0]   dvd    [3];
    logic          ge     [3];
    logic [RW:0]   diff   [3];
    logic [3*RW-1:0] n_rem;
    logic [3*QW-1:0] n_quo;

    t_vnu_ctl        r_ctl;
    logic [W-1:0]    r_len;
    logic [3*RW-1:0] r_rem;
    logic [3*QW-1:0] r_quo;

    // First stage compares the magnitude as is; later stages shift in a zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_in[k] = i_rem[k*RW +: RW];
            quo_in[k] = i_quo[k*QW +: QW];
            dvd[k]    = FIRST ? {1'b0, rem_in[k]} : {rem_in[k], 1'b0};
            ge[k]     = (dvd[k] >= {2'b00, i_len});
            diff[k]   = dvd[k] - {2'b00, i_len};
            n_rem[k*RW +: RW] = ge[k] ? diff[k][RW-1:0] : dvd[k][RW-1:0];
            n_quo[k*QW +: QW] = {quo_in[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= i_len;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_ctl = r_ctl;
    assign o_len = r_len;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

/* rtl/vector_normalize_unit.sv */
// Top level of the vector normalize unit.
//
// Usage: a request (i_req: comp_x, comp_y, comp_z) is taken at each rising
// edge where start is high and busy is low. busy is always low, so one
// request can enter every cycle and the unit sustains one vector per clock.
// Each result appears on o_res for exactly one cycle, flagged by o_valid,
// in request order; the receiver has no way to stall it.
// From the accepting edge a request passes through the magnitude, square
// and sum stages, a row of 16 square-root cells (one root bit each),
// FRAC_BITS+1 divider cells (one quotient bit per cell, three lanes),
// then the output register.
// i_cfg_we / i_cfg_data write zero_length_mode at the next edge; mode 0
// returns (0,0,1.0) for a zero vector, mode 1 returns all zeros. Change it
// only with no request in flight.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and the
// mode register; requests in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module vector_normalize_unit #(
    parameter int FRAC_BITS = 14
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  vnu_pkg::t_vnu_req i_req,
    output logic              o_valid,
    output vnu_pkg::t_vnu_res o_res,
    input  wire               i_cfg_we,
    input  wire               i_cfg_data
);
    import vnu_pkg::*;

    localparam int W  = COMP_W;
    localparam int RW = COMP_W + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int EW = FRAC_BITS + 2 + OUT_W;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic r_mode;

    // Stage 1: sign and magnitude
    t_vnu_ctl       r_s1_ctl;
    logic [W-1:0]   r_s1_mag [3];
    logic [W-1:0]   comp     [3];
    // Stage 2: squares
    t_vnu_ctl       r_s2_ctl;
    logic [W-1:0]   r_s2_mag [3];
    logic [2*W-1:0] r_s2_sq  [3];
    // Stage 3: sum of squares
    t_vnu_ctl       r_s3_ctl;
    logic [3*W-1:0] r_s3_mag;
    logic [2*W-1:0] r_s3_sum;
    logic [2*W+1:0] sum_full;

    t_vnu_ctl       sq_ctl  [W+1];
    logic [3*W-1:0] sq_mag  [W+1];
    logic [2*W-1:0] sq_sum  [W+1];
    logic [W+1:0]   sq_rem  [W+1];
    logic [W-1:0]   sq_root [W+1];

    t_vnu_ctl        dv_ctl [QW+1];
    logic [W-1:0]    dv_len [QW+1];
    logic [3*RW-1:0] dv_rem [QW+1];
    logic [3*QW-1:0] dv_quo [QW+1];

    logic [QW-1:0] quo  [3];
    logic [QW-1:0] qsat [3];
    logic [EW-1:0] qext [3];
    logic [OUT_W-1:0] unit [3];
    t_vnu_res n_res;
    t_vnu_res r_res;
    logic     r_valid;
    t_vnu_ctl last_ctl;

    assign busy = 1'b0;
    assign comp[0] = i_req.comp_x;
    assign comp[1] = i_req.comp_y;
    assign comp[2] = i_req.comp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_s1_ctl.valid <= start && !busy;
            r_s1_ctl.zero  <= 1'b0;
            r_s1_ctl.neg   <= {comp[2][W-1], comp[1][W-1], comp[0][W-1]};
            r_s2_ctl       <= r_s1_ctl;
            r_s3_ctl       <= r_s2_ctl;
            r_valid        <= last_ctl.valid;
        end
    end

    assign sum_full = {2'b00, r_s2_sq[0]} + {2'b00, r_s2_sq[1]} + {2'b00, r_s2_sq[2]};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s1_mag[k] <= comp[k][W-1] ? (W'(0) - comp[k]) : comp[k];
            r_s2_mag[k] <= r_s1_mag[k];
            r_s2_sq[k]  <= r_s1_mag[k] * r_s1_mag[k];
        end
        r_s3_mag <= {r_s2_mag[2], r_s2_mag[1], r_s2_mag[0]};
        // three squares of at most 2^(2W-2) fit in 2W bits
        r_s3_sum <= sum_full[2*W-1:0];
    end

    assign sq_ctl[0]  = r_s3_ctl;
    assign sq_mag[0]  = r_s3_mag;
    assign sq_sum[0]  = r_s3_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < W; i++) begin : g_sqrt
        vnu_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (sq_ctl[i]),
            .i_mag  (sq_mag[i]),
            .i_sum  (sq_sum[i]),
            .i_rem  (sq_rem[i]),
            .i_root (sq_root[i]),
            .o_ctl  (sq_ctl[i+1]),
            .o_mag  (sq_mag[i+1]),
            .o_sum  (sq_sum[i+1]),
            .o_rem  (sq_rem[i+1]),
            .o_root (sq_root[i+1])
        );
    end

    // Zero length is known once the root is complete; a zero root divides by
    // zero harmlessly, the result is replaced at the output
    always_comb begin
        dv_ctl[0]      = sq_ctl[W];
        dv_ctl[0].zero = (sq_root[W] == '0);
        dv_len[0]      = sq_root[W];
        for (int k = 0; k < 3; k++) begin
            dv_rem[0][k*RW +: RW] = {1'b0, sq_mag[W][k*W +: W]};
        end
        dv_quo[0] = '0;
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        vnu_div_cell #(
            .FRAC_BITS(FRAC_BITS),
            .FIRST    (j == 0)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (dv_ctl[j]),
            .i_len  (dv_len[j]),
            .i_rem  (dv_rem[j]),
            .i_quo  (dv_quo[j]),
            .o_ctl  (dv_ctl[j+1]),
            .o_len  (dv_len[j+1]),
            .o_rem  (dv_rem[j+1]),
            .o_quo  (dv_quo[j+1])
        );
    end

    assign last_ctl = dv_ctl[QW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quo[k]  = dv_quo[QW][k*QW +: QW];
            qsat[k] = (quo[k] > ONE_Q) ? ONE_Q : quo[k];
            qext[k] = last_ctl.neg[k] ? (EW'(0) - EW'(qsat[k])) : EW'(qsat[k]);
            unit[k] = qext[k][OUT_W-1:0];
        end
        if (last_ctl.zero) begin
            n_res.unit_x   = '0;
            n_res.unit_y   = '0;
            n_res.unit_z   = r_mode ? '0 : OUT_W'(ONE_Q);
            n_res.was_zero = 1'b1;
        end else begin
            n_res.unit_x   = unit[0];
            n_res.unit_y   = unit[1];
            n_res.unit_z   = unit[2];
            n_res.was_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.was_zero) |-> (o_res.unit_x == '0 && o_res.unit_y == '0))
        else $error("zero vector with nonzero x/y");
    a_zero_mode1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.was_zero && r_mode) |-> (o_res.unit_z == '0))
        else $error("zero vector in mode 1 with nonzero z");
    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_ctl.valid |=> o_valid)
        else $error("result lost at output register");

endmodule

`default_nettype wire

/* dv/tb_vector_normalize_unit.sv */
// Self-checking testbench for the vector normalize unit.
`timescale 1ns / 1ps

module tb_vector_normalize_unit;
    import vnu_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 20 + FRAC;
    localparam int CYCLE_LIMIT = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_vnu_req req = '0;
    logic     res_valid;
    t_vnu_res res;
    logic     cfg_we = 1'b0;
    logic     cfg_data = 1'b0;

    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;
    logic zero_mode = 1'b0;

    always #5 clk = ~clk;

    vector_normalize_unit #(.FRAC_BITS(FRAC)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_req(req), .o_valid(res_valid), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    task automatic report(input string what, input t_vnu_res got, input t_vnu_res want);
        $display("mismatch %s: got %0d %0d %0d z%0b want %0d %0d %0d z%0b", what,
                 got.unit_x, got.unit_y, got.unit_z, got.was_zero,
                 want.unit_x, want.unit_y, want.unit_z, want.was_zero);
        errors++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r |= 64'd1 << b;
        return r;
    endfunction

    function automatic logic signed [15:0] unit_comp(input logic signed [15:0] c,
                                                     input logic [63:0] len);
        logic [63:0] mag, q;
        mag = c < 0 ? 64'(-32'(c)) : 64'(c);
        q = (mag << FRAC) / len;
        if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
        return c < 0 ? -16'(q) : 16'(q);
    endfunction

    function automatic t_vnu_res normalize(input t_vnu_req v, input logic mode);
        t_vnu_res r;
        logic [63:0] sum, len;
        sum = 64'(32'(v.comp_x) * 32'(v.comp_x)) + 64'(32'(v.comp_y) * 32'(v.comp_y))
            + 64'(32'(v.comp_z) * 32'(v.comp_z));
        len = floor_sqrt(sum);
        r = '0;
        if (len == 0) begin
            r.unit_z = mode ? 16'sd0 : 16'sd16384;
            r.was_zero = 1'b1;
        end else begin
            r.unit_x = unit_comp(v.comp_x, len);
            r.unit_y = unit_comp(v.comp_y, len);
            r.unit_z = unit_comp(v.comp_z, len);
        end
        return r;
    endfunction

    class unit_scoreboard;
        t_vnu_res pending[$];
        function void note_request(t_vnu_req v, logic mode);
            pending.push_back(normalize(v, mode));
        endfunction
        task check_result(t_vnu_res got);
            t_vnu_res want;
            if (pending.size() == 0) begin
                report("unexpected result", got, '0);
                return;
            end
            want = pending.pop_front();
            if (got.unit_x !== want.unit_x) report("unit_x", got, want);
            if (got.unit_y !== want.unit_y) report("unit_y", got, want);
            if (got.unit_z !== want.unit_z) report("unit_z", got, want);
            if (got.was_zero !== want.was_zero) report("was_zero", got, want);
        endtask
    endclass

    unit_scoreboard board = new();

    always @(posedge clk) begin
        cycles++;
        if (rst_n && start && !busy) board.note_request(req, zero_mode);
        if (rst_n && res_valid) board.check_result(res);
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // start stays high between back-to-back requests; it drops on idle cycles
    // and in drain
    task automatic send(input t_vnu_req v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_vnu_req v;
        v.comp_x = 16'(x);
        v.comp_y = 16'(y);
        v.comp_z = 16'(z);
        send(v);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        zero_mode = m;
    endtask

    task automatic random_item();
        t_vnu_req v;
        int k;
        v.comp_x = 16'($urandom);
        v.comp_y = 16'($urandom);
        v.comp_z = 16'($urandom);
        k = $urandom_range(9);
        // small vectors stress the floor length and saturation
        if (k < 3) begin
            v.comp_x = 16'($signed($urandom_range(6)) - 3);
            v.comp_y = 16'($signed($urandom_range(6)) - 3);
            v.comp_z = 16'($signed($urandom_range(6)) - 3);
        end else if (k == 3) begin
            v.comp_y = '0;
            v.comp_z = '0;
        end else if (k == 4) begin
            v = '0;
        end
        send(v);
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset mode is 0: zero vector gives (0,0,1.0)
        send_xyz(0, 0, 0);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, -32768, -32768);
        send_xyz(-32768, 0, 0);
        send_xyz(0, 32767, 0);
        send_xyz(0, 0, -32768);
        send_xyz(1, 1, 0);
        send_xyz(1, 1, 1);
        send_xyz(-1, 2, -2);
        send_xyz(3, 0, -1);
        send_xyz(32767, -32768, 1);
        drain();
        set_mode(1'b1);
        send_xyz(0, 0, 0);
        send_xyz(1, 0, 0);
        send_xyz(-1, -1, -1);
        send_xyz(0, 0, 0);
        drain();
        set_mode(1'b0);

        idle_pct = 36;
        repeat (300) random_item();
        drain();
        set_mode(1'b1);
        idle_pct = 82;
        repeat (300) random_item();
        // hold off until everything is back
        drain();
        set_mode(1'b0);
        idle_pct = 0;
        repeat (150) random_item();
        drain();
        set_mode(1'b1);
        repeat (150) random_item();
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/vnu_pkg.sv
rtl/vnu_sqrt_cell.sv
rtl/vnu_div_cell.sv
rtl/vector_normalize_unit.sv
dv/tb_vector_normalize_unit.sv
